FILE: rtl/core/offline_stack_top_tracker_macros.svh
// ----------------------------------------------------------------------------
// Offline stack top tracker assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OFFLINE_STACK_TOP_TRACKER_MACROS_SVH
`define OFFLINE_STACK_TOP_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/ost_pkg.sv
// ----------------------------------------------------------------------------
// Offline stack top tracker package
// Sizes, payload types, datapath command codes and balance helpers.
// ----------------------------------------------------------------------------
package ost_pkg;

   // Tree geometry.
   localparam int POSITIONS = 1024;
   localparam int DEPTH     = $clog2(POSITIONS);
   localparam int NODE_W    = DEPTH + 1;
   localparam int NODES     = 2 * POSITIONS;
   localparam int DEPTH_W   = $clog2(DEPTH + 1);

   // Field widths.
   localparam int POS_W = 11;
   localparam int VAL_W = 20;
   localparam int BAL_W = 12;

   localparam logic [BAL_W-1:0] BAL_PLUS_ONE  = BAL_W'(1);
   localparam logic [BAL_W-1:0] BAL_MINUS_ONE = '1;
   localparam logic [NODE_W-1:0] ROOT_NODE    = NODE_W'(1);

   // Datapath command codes.
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 4'd1;
   localparam logic [OP_W-1:0] OP_ACCEPT = 4'd2;
   localparam logic [OP_W-1:0] OP_U_RD   = 4'd3;
   localparam logic [OP_W-1:0] OP_U_WR   = 4'd4;
   localparam logic [OP_W-1:0] OP_F_RD   = 4'd5;
   localparam logic [OP_W-1:0] OP_F_WR   = 4'd6;
   localparam logic [OP_W-1:0] OP_UP     = 4'd7;
   localparam logic [OP_W-1:0] OP_R_RD   = 4'd8;
   localparam logic [OP_W-1:0] OP_R_EV   = 4'd9;
   localparam logic [OP_W-1:0] OP_C_RD   = 4'd10;
   localparam logic [OP_W-1:0] OP_C_EV   = 4'd11;
   localparam logic [OP_W-1:0] OP_S_RD   = 4'd12;
   localparam logic [OP_W-1:0] OP_LOAD   = 4'd13;

   typedef struct packed {
      logic             action;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic             top_valid;
      logic [VAL_W-1:0] top_value;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [DEPTH_W-1:0] depth;
      logic [NODE_W-1:0]  clr_addr;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic root_full;
      logic child_full;
      logic root_positive;
      logic child_positive;
      logic rsp_busy;
   } status_type;

   // A balance is positive when it is nonzero with a clear sign bit.
   function automatic logic bal_positive(input logic [BAL_W-1:0] v);
      return !v[BAL_W-1] && (v != '0);
   endfunction

   // Signed maximum, ties take the first operand.
   function automatic logic [BAL_W-1:0] bal_max(input logic [BAL_W-1:0] a,
                                               input logic [BAL_W-1:0] b);
      return ($signed(a) >= $signed(b)) ? a : b;
   endfunction

endpackage

FILE: rtl/core/ost_datapath.sv
// ----------------------------------------------------------------------------
// Offline stack top tracker datapath
// Balance and pending-add memories, value store, path walk arithmetic and
// the result register.
// ----------------------------------------------------------------------------
module ost_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ost_pkg::cmd_type    cmd,
   output ost_pkg::status_type status,
   input  logic                req_valid,
   input  ost_pkg::req_type    req_data,
   output logic                rsp_valid,
   output ost_pkg::rsp_type    rsp_data,
   input  logic                rsp_stall
);

   // Memories.
   logic [ost_pkg::BAL_W-1:0] bal_mem   [ost_pkg::NODES];
   logic [ost_pkg::BAL_W-1:0] pend_mem  [ost_pkg::NODES];
   logic [ost_pkg::VAL_W-1:0] store_mem [ost_pkg::POSITIONS];

   logic [ost_pkg::BAL_W-1:0] bal_qa_ff, bal_qb_ff, pend_qa_ff, pend_qb_ff;
   logic [ost_pkg::VAL_W-1:0] store_q_ff;

   logic                       bal_we, pend_we;
   logic [ost_pkg::NODE_W-1:0] bal_wa, pend_wa, bal_raa, bal_rab, pend_raa, pend_rab;
   logic [ost_pkg::BAL_W-1:0]  bal_wd, pend_wd;

   // Item and walk registers.
   logic                        act_ff;
   logic [ost_pkg::DEPTH-1:0]   leaf_ff;
   logic [ost_pkg::BAL_W-1:0]   carry_ff, run_ff, fcarry_ff;
   logic [ost_pkg::BAL_W-1:0]   sibval_ff [ost_pkg::DEPTH+1];
   logic [ost_pkg::NODE_W-1:0]  fnode_ff;
   logic                        empty_ff;
   logic                        rsp_valid_ff;
   ost_pkg::rsp_type            rsp_data_ff;

   logic                        accept;
   logic [ost_pkg::DEPTH-1:0]   req_leaf;
   logic                        req_in_range;
   logic [ost_pkg::DEPTH_W-1:0] kp1;
   logic [ost_pkg::NODE_W-1:0]  node_k, node_k1, sib_node, left_node, right_node;
   logic                        sib_right;
   logic [ost_pkg::BAL_W-1:0]   delta, eff, sib_new, full_new, up_val, root_v, lv, rv;
   logic [ost_pkg::DEPTH-1:0]   low_mask;

   // Path node at depth k on the way to the latched leaf.
   function automatic logic [ost_pkg::NODE_W-1:0] path_node(
      input logic [ost_pkg::DEPTH-1:0]   leaf,
      input logic [ost_pkg::DEPTH_W-1:0] k);
      logic [ost_pkg::DEPTH_W-1:0] sh;
      sh = ost_pkg::DEPTH_W'(ost_pkg::DEPTH) - k;
      return {1'b1, leaf} >> sh;
   endfunction

   // Incoming item decode.
   assign accept       = (cmd.op == ost_pkg::OP_ACCEPT) && req_valid;
   assign req_in_range = (req_data.position != '0) &&
                         (32'(req_data.position) <= 32'(ost_pkg::POSITIONS));
   assign req_leaf     = ost_pkg::DEPTH'(32'(ost_pkg::POSITIONS) - 32'(req_data.position));

   // Walk arithmetic.
   assign kp1        = cmd.depth + ost_pkg::DEPTH_W'(1);
   assign node_k     = path_node(leaf_ff, cmd.depth);
   assign node_k1    = path_node(leaf_ff, kp1);
   assign sib_node   = node_k1 ^ ost_pkg::NODE_W'(1);
   assign sib_right  = ~node_k1[0];
   assign delta      = act_ff ? ost_pkg::BAL_PLUS_ONE : ost_pkg::BAL_MINUS_ONE;
   assign eff        = pend_qa_ff + carry_ff;
   assign sib_new    = pend_qb_ff + eff + (sib_right ? delta : '0);
   assign full_new   = pend_qa_ff + carry_ff + delta;
   assign up_val     = ost_pkg::bal_max(run_ff, sibval_ff[kp1]);
   assign root_v     = bal_qa_ff + pend_qa_ff;
   assign left_node  = {fnode_ff[ost_pkg::NODE_W-2:0], 1'b0};
   assign right_node = {fnode_ff[ost_pkg::NODE_W-2:0], 1'b1};
   assign lv         = bal_qa_ff + pend_qa_ff + fcarry_ff;
   assign rv         = bal_qb_ff + pend_qb_ff + fcarry_ff;
   assign low_mask   = ~({ost_pkg::DEPTH{1'b1}} <<
                         (ost_pkg::DEPTH_W'(ost_pkg::DEPTH - 1) - cmd.depth));

   // Status back to the controller.
   always_comb begin
      status.in_range       = req_in_range;
      status.root_full      = (req_leaf == '0);
      status.child_full     = ((leaf_ff & low_mask) == '0);
      status.root_positive  = ost_pkg::bal_positive(root_v);
      status.child_positive = ost_pkg::bal_positive(lv) || ost_pkg::bal_positive(rv);
      status.rsp_busy       = rsp_valid_ff && rsp_stall;
   end

   // Memory port selection per command.
   always_comb begin
      bal_we   = 1'b0;
      pend_we  = 1'b0;
      bal_wa   = '0;
      pend_wa  = '0;
      bal_wd   = '0;
      pend_wd  = '0;
      bal_raa  = '0;
      bal_rab  = '0;
      pend_raa = '0;
      pend_rab = '0;
      unique case (cmd.op)
         ost_pkg::OP_CLEAR: begin
            bal_we  = 1'b1;
            pend_we = 1'b1;
            bal_wa  = cmd.clr_addr;
            pend_wa = cmd.clr_addr;
         end
         ost_pkg::OP_U_RD: begin
            pend_raa = node_k;
            pend_rab = sib_node;
            bal_rab  = sib_node;
         end
         ost_pkg::OP_U_WR: begin
            pend_we = 1'b1;
            pend_wa = sib_node;
            pend_wd = sib_new;
         end
         ost_pkg::OP_F_RD: begin
            pend_raa = node_k;
            bal_raa  = node_k;
         end
         ost_pkg::OP_F_WR: begin
            pend_we = 1'b1;
            pend_wa = node_k;
            pend_wd = full_new;
         end
         ost_pkg::OP_UP: begin
            bal_we  = 1'b1;
            bal_wa  = node_k;
            bal_wd  = up_val;
            pend_we = 1'b1;
            pend_wa = node_k;
         end
         ost_pkg::OP_R_RD: begin
            bal_raa  = ost_pkg::ROOT_NODE;
            pend_raa = ost_pkg::ROOT_NODE;
         end
         ost_pkg::OP_C_RD: begin
            bal_raa  = left_node;
            pend_raa = left_node;
            bal_rab  = right_node;
            pend_rab = right_node;
         end
         default: begin
         end
      endcase
   end

   // Balance memory with two registered read ports.
   always_ff @(posedge clock) begin
      if (bal_we) begin
         bal_mem[bal_wa] <= bal_wd;
      end
      bal_qa_ff <= bal_mem[bal_raa];
      bal_qb_ff <= bal_mem[bal_rab];
   end

   // Pending-add memory with two registered read ports.
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_wa] <= pend_wd;
      end
      pend_qa_ff <= pend_mem[pend_raa];
      pend_qb_ff <= pend_mem[pend_rab];
   end

   // Value store, written by a push and read at the found leaf.
   always_ff @(posedge clock) begin
      if (accept && req_in_range && req_data.action) begin
         store_mem[req_leaf] <= req_data.push_value;
      end
      store_q_ff <= store_mem[fnode_ff[ost_pkg::DEPTH-1:0]];
   end

   // Walk registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req_data.action;
         leaf_ff  <= req_leaf;
         carry_ff <= '0;
         empty_ff <= 1'b0;
      end
      unique case (cmd.op)
         ost_pkg::OP_U_WR: begin
            carry_ff       <= eff;
            sibval_ff[kp1] <= bal_qb_ff + sib_new;
         end
         ost_pkg::OP_F_WR: begin
            run_ff <= bal_qa_ff + full_new;
         end
         ost_pkg::OP_UP: begin
            run_ff <= up_val;
         end
         ost_pkg::OP_R_EV: begin
            fnode_ff  <= ost_pkg::ROOT_NODE;
            fcarry_ff <= pend_qa_ff;
            if (!ost_pkg::bal_positive(root_v)) begin
               empty_ff <= 1'b1;
            end
         end
         ost_pkg::OP_C_EV: begin
            priority if (ost_pkg::bal_positive(lv)) begin
               fnode_ff  <= left_node;
               fcarry_ff <= fcarry_ff + pend_qa_ff;
            end else if (ost_pkg::bal_positive(rv)) begin
               fnode_ff  <= right_node;
               fcarry_ff <= fcarry_ff + pend_qb_ff;
            end else begin
               empty_ff <= 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Result register; a new result loads only when the slot is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == ost_pkg::OP_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == ost_pkg::OP_LOAD) begin
         rsp_data_ff.top_valid <= !empty_ff;
         rsp_data_ff.top_value <= empty_ff ? '0 : store_q_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/ost_controller.sv
// ----------------------------------------------------------------------------
// Offline stack top tracker controller
// Sequences the clearing pass, the range update walk and the top search.
// ----------------------------------------------------------------------------
module ost_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ost_pkg::status_type status,
   output ost_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_U_RD  = 4'd2;
   localparam logic [3:0] S_U_WR  = 4'd3;
   localparam logic [3:0] S_F_RD  = 4'd4;
   localparam logic [3:0] S_F_WR  = 4'd5;
   localparam logic [3:0] S_UP    = 4'd6;
   localparam logic [3:0] S_R_RD  = 4'd7;
   localparam logic [3:0] S_R_EV  = 4'd8;
   localparam logic [3:0] S_C_RD  = 4'd9;
   localparam logic [3:0] S_C_EV  = 4'd10;
   localparam logic [3:0] S_S_RD  = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0]                  state_ff, state_in;
   logic [ost_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic [ost_pkg::NODE_W-1:0]  clr_ff, clr_in;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      clr_in       = clr_ff;
      cmd.op       = ost_pkg::OP_NONE;
      cmd.depth    = depth_ff;
      cmd.clr_addr = clr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = ost_pkg::OP_CLEAR;
            clr_in = clr_ff + ost_pkg::NODE_W'(1);
            if (clr_ff == ost_pkg::NODE_W'(ost_pkg::NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.op   = ost_pkg::OP_ACCEPT;
            depth_in = '0;
            if (req_valid) begin
               priority if (!status.in_range) begin
                  state_in = S_R_RD;
               end else if (status.root_full) begin
                  state_in = S_F_RD;
               end else begin
                  state_in = S_U_RD;
               end
            end
         end
         S_U_RD: begin
            cmd.op   = ost_pkg::OP_U_RD;
            state_in = S_U_WR;
         end
         S_U_WR: begin
            cmd.op   = ost_pkg::OP_U_WR;
            depth_in = depth_ff + ost_pkg::DEPTH_W'(1);
            state_in = status.child_full ? S_F_RD : S_U_RD;
         end
         S_F_RD: begin
            cmd.op   = ost_pkg::OP_F_RD;
            state_in = S_F_WR;
         end
         S_F_WR: begin
            cmd.op = ost_pkg::OP_F_WR;
            if (depth_ff == '0) begin
               state_in = S_R_RD;
            end else begin
               depth_in = depth_ff - ost_pkg::DEPTH_W'(1);
               state_in = S_UP;
            end
         end
         S_UP: begin
            cmd.op = ost_pkg::OP_UP;
            if (depth_ff == '0) begin
               state_in = S_R_RD;
            end else begin
               depth_in = depth_ff - ost_pkg::DEPTH_W'(1);
            end
         end
         S_R_RD: begin
            cmd.op   = ost_pkg::OP_R_RD;
            state_in = S_R_EV;
         end
         S_R_EV: begin
            cmd.op   = ost_pkg::OP_R_EV;
            depth_in = '0;
            state_in = status.root_positive ? S_C_RD : S_DONE;
         end
         S_C_RD: begin
            cmd.op   = ost_pkg::OP_C_RD;
            state_in = S_C_EV;
         end
         S_C_EV: begin
            cmd.op = ost_pkg::OP_C_EV;
            priority if (!status.child_positive) begin
               state_in = S_DONE;
            end else if (depth_ff == ost_pkg::DEPTH_W'(ost_pkg::DEPTH - 1)) begin
               state_in = S_S_RD;
            end else begin
               depth_in = depth_ff + ost_pkg::DEPTH_W'(1);
               state_in = S_C_RD;
            end
         end
         S_S_RD: begin
            cmd.op   = ost_pkg::OP_S_RD;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!status.rsp_busy) begin
               cmd.op   = ost_pkg::OP_LOAD;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         depth_ff <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         clr_ff   <= clr_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

FILE: rtl/core/offline_stack_top_tracker.sv
// ----------------------------------------------------------------------------
// Offline stack top tracker, top level
// Range add on a lazy max tree plus a leftmost-positive search per item.
// ----------------------------------------------------------------------------
//  channel  direction  payload     transfer
//  req      in         req_type    req_valid high, req_stall low
//  rsp      out        rsp_type    rsp_valid high, rsp_stall low
//
//  An in-range item runs the range update walk and then the top search; an
//  out-of-range item skips the update, and an empty tree ends the search
//  after the root.
//  After reset a clearing pass sweeps 2048 tree nodes, one a cycle, with
//  req_stall high. A stalled rsp holds only the final load of the next item.
// ----------------------------------------------------------------------------
`include "offline_stack_top_tracker_macros.svh"

module offline_stack_top_tracker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ost_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ost_pkg::rsp_type rsp_data
);

   ost_pkg::cmd_type    cmd;
   ost_pkg::status_type status;

   // Sequencer.
   ost_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Tree memories and arithmetic.
   ost_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // An accepted item keeps the input closed on the following cycle.
   `OST_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "input not closed")
   // An empty result carries a zero value.
   `OST_ASSERT_NOW(a_empty_zero, rsp_valid && !rsp_data.top_valid, rsp_data.top_value == '0, "empty")
   // A new result only appears at the end of an item's work.
   `OST_ASSERT_NOW(a_result_from_work, $rose(rsp_valid), $past(req_stall), "stray result")

endmodule
